>>> src/decimal_expression_evaluator_defines.svh
// Assertion macros for the RTL files.
`ifndef DECIMAL_EXPRESSION_EVALUATOR_DEFINES_SVH
`define DECIMAL_EXPRESSION_EVALUATOR_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define DEE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// An implication checked in the same cycle.
`define DEE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

>>> src/dee_pkg.sv
`default_nettype none
package dee_pkg;

    localparam int DEE_FRAC_BITS = 32;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [3:0] FRAC_LAST = 4'd10;

    typedef enum logic [2:0] {PH_NUM, PH_INT, PH_FRAC, PH_AFTER, PH_ERR} phase_t;
    typedef enum logic [1:0] {MOP_NONE, MOP_MUL, MOP_DIV} mul_op_t;
    typedef enum logic [1:0] {ST_OK, ST_SYNTAX, ST_DIV0, ST_OVF} status_t;
    typedef enum logic [2:0] {S_IDLE, S_STEP, S_NUMF, S_WAIT, S_CONT, S_OPER, S_FIN} state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_cmd_t;

    typedef struct packed {
        logic done;
        logic ovf;
        logic busy;
    } md_rsp_t;

    // Weight of the next fraction digit in Q0.32; it decays by tenths to zero.
    function automatic logic [31:0] frac_weight(input logic [3:0] idx);
        logic [31:0] w;
        begin
            case (idx)
                4'd0:    w = 32'd429496730;
                4'd1:    w = 32'd42949673;
                4'd2:    w = 32'd4294967;
                4'd3:    w = 32'd429497;
                4'd4:    w = 32'd42950;
                4'd5:    w = 32'd4295;
                4'd6:    w = 32'd430;
                4'd7:    w = 32'd43;
                4'd8:    w = 32'd4;
                default: w = 32'd0;
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

>>> src/dee_in_if.sv
`default_nettype none
interface dee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink (input valid, input ch, input end_of_text, output ready);
endinterface
`default_nettype wire

>>> src/dee_out_if.sv
`default_nettype none
interface dee_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

>>> src/dee_muldiv.sv
`default_nettype none
module dee_muldiv
    import dee_pkg::*;
#(
    parameter int FRAC_BITS = DEE_FRAC_BITS
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire md_cmd_t     cmd,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output md_rsp_t          rsp,
    output logic [63:0]      result
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic         div_reg, div_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [127:0] p_reg, p_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  b_reg, b_next;
    logic [63:0]  x;
    logic [63:0]  y;
    logic [64:0]  s;

    // One 65-bit adder: adds the multiplicand or subtracts the divisor.
    assign x = div_reg ? {rem_reg[62:0], p_reg[127]} : p_reg[127:64];
    assign y = div_reg ? ~b_reg : b_reg;
    assign s = {1'b0, x} + {1'b0, y} + {64'd0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        rem_next  = rem_reg;
        b_next    = b_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            div_next  = cmd.is_div;
            cnt_next  = cmd.is_div ? 8'd128 : 8'd64;
            p_next    = cmd.is_div ? ({64'd0, a} << FRAC_BITS) : {64'd0, a};
            rem_next  = 64'd0;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg)
            begin
                rem_next = s[64] ? s[63:0] : x;
                p_next   = {p_reg[126:0], s[64]};
            end
            else
            begin
                p_next = p_reg[0] ? {s, p_reg[63:1]} : {1'b0, p_reg[127:64], p_reg[63:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.ovf  = div_reg ? (|p_reg[127:63]) : (|p_reg[127:FRAC_BITS+63]);
    assign result   = div_reg ? p_reg[63:0] : {1'b0, p_reg[FRAC_BITS+62:FRAC_BITS]};

endmodule
`default_nettype wire

>>> src/decimal_expression_evaluator.sv
// Decimal expression evaluator.
// The text channel carries one character word per handshake; a word with
// end_of_text set closes the expression and yields one result word on the
// result channel: a signed fixed-point value with FRAC_BITS fraction bits
// and a status (0 ok, 1 syntax error, 2 division by zero, 3 overflow).
// Words are taken one at a time; each passes S_STEP, one that closes a
// number also S_NUMF (and S_WAIT for a product or quotient) and S_CONT,
// and an operator S_OPER, before the next word is taken. In S_WAIT the
// shared shift-add or restoring-divide unit runs one bit per cycle.
// The result word is written to the output register in S_FIN, after the
// end marker has passed S_STEP, or S_STEP, S_NUMF and S_CONT when it
// closes a number, with S_WAIT for a product or a quotient.
// The result sits in an output register; a stalled receiver holds it, and
// the block keeps taking characters until the next end marker, which waits
// for the register to drain. Reset clears the parse state and drops any
// pending result; the block is ready in the first cycle after reset.
`default_nettype none
`include "decimal_expression_evaluator_defines.svh"
module decimal_expression_evaluator
    import dee_pkg::*;
#(
    parameter int FRAC_BITS = DEE_FRAC_BITS
)(
    input wire logic clk,
    input wire logic rst_n,
    dee_in_if.sink   text,
    dee_out_if.source result
);

    localparam int SHL = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
    localparam int SHR = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 1;
    localparam logic [63:0] RND = 64'd1 << (SHR - 1);

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    mul_op_t            mop_reg, mop_next;
    status_t            err_reg, err_next;
    logic               add_op_reg, add_op_next;
    logic [3:0]         fidx_reg, fidx_next;
    logic signed [63:0] sum_reg, sum_next;
    logic [63:0]        term_reg, term_next;
    logic [63:0]        num_reg, num_next;
    logic [7:0]         c_reg, c_next;
    logic               eot_reg, eot_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [63:0] out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;

    md_cmd_t     md_cmd;
    md_rsp_t     md_rsp;
    logic [63:0] md_result;

    logic        accept;
    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [67:0] n68;
    logic [67:0] int_sum;
    logic [63:0] fprod;
    logic [63:0] fx;
    logic [64:0] frac_sum;
    logic [64:0] t65;
    logic [64:0] fold;
    logic        fold_ovf;
    logic        div_zero;
    logic        slot_free;
    logic        do_fold;
    status_t     fin_status;

    function automatic status_t keep_first(input status_t cur, input status_t code);
        begin
            return (cur == ST_OK) ? code : cur;
        end
    endfunction

    dee_muldiv #(
        .FRAC_BITS(FRAC_BITS)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (md_cmd),
        .a     (term_reg),
        .b     (num_reg),
        .rsp   (md_rsp),
        .result(md_result)
    );

    assign accept    = text.valid && text.ready;
    assign is_digit  = (c_reg >= CH_ZERO) && (c_reg <= CH_NINE);
    assign is_space  = (c_reg == CH_SPACE) || ((c_reg >= CH_TAB) && (c_reg <= CH_CR));
    assign digit     = 4'(c_reg - CH_ZERO);
    assign n68       = {4'd0, num_reg};
    assign int_sum   = (n68 << 3) + (n68 << 1) + ({64'd0, digit} << FRAC_BITS);
    assign fprod     = {60'd0, digit} * {32'd0, frac_weight(fidx_reg)};
    assign fx        = (FRAC_BITS >= 32) ? (fprod << SHL) : ((fprod + RND) >> SHR);
    assign frac_sum  = {1'b0, num_reg} + {1'b0, fx};
    assign t65       = {1'b0, term_reg};
    assign fold      = add_op_reg ? ({sum_reg[63], sum_reg} - t65)
                                  : ({sum_reg[63], sum_reg} + t65);
    assign fold_ovf  = fold[64] ^ fold[63];
    assign div_zero  = (mop_reg == MOP_DIV) && (num_reg == 64'd0);
    assign slot_free = !out_valid_reg || result.ready;
    assign do_fold   = (err_reg == ST_OK) && (phase_reg == PH_AFTER);
    assign fin_status = (err_reg != ST_OK) ? err_reg : ((do_fold && fold_ovf) ? ST_OVF : ST_OK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (eot_reg)
                    state_next = (phase_reg == PH_INT || phase_reg == PH_FRAC) ? S_NUMF : S_FIN;
                else if ((phase_reg == PH_INT || phase_reg == PH_FRAC) && !is_digit
                         && !(c_reg == CH_DOT && phase_reg == PH_INT))
                    state_next = S_NUMF;
                else if (phase_reg == PH_AFTER && !is_space)
                    state_next = S_OPER;
                else
                    state_next = S_IDLE;
            end
            S_NUMF:
            begin
                state_next = (mop_reg == MOP_NONE || div_zero) ? S_CONT : S_WAIT;
            end
            S_WAIT:
            begin
                if (md_rsp.done)
                    state_next = S_CONT;
            end
            S_CONT:
            begin
                if (eot_reg)
                    state_next = S_FIN;
                else if (err_reg == ST_OK && !is_space)
                    state_next = S_OPER;
                else
                    state_next = S_IDLE;
            end
            S_OPER:
            begin
                state_next = S_IDLE;
            end
            S_FIN:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        text.ready    = (state_reg == S_IDLE);
        md_cmd.start  = (state_reg == S_NUMF) && (mop_reg != MOP_NONE) && !div_zero;
        md_cmd.is_div = (mop_reg == MOP_DIV);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        mop_next        = mop_reg;
        err_next        = err_reg;
        add_op_next     = add_op_reg;
        fidx_next       = fidx_reg;
        sum_next        = sum_reg;
        term_next       = term_reg;
        num_next        = num_reg;
        c_next          = c_reg;
        eot_next        = eot_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    c_next   = text.ch;
                    eot_next = text.end_of_text;
                end
            end
            S_STEP:
            begin
                if (eot_reg)
                begin
                    if (phase_reg == PH_NUM)
                    begin
                        err_next   = keep_first(err_reg, ST_SYNTAX);
                        phase_next = PH_ERR;
                    end
                end
                else if (phase_reg == PH_NUM)
                begin
                    if (is_digit)
                    begin
                        num_next   = {60'd0, digit} << FRAC_BITS;
                        phase_next = PH_INT;
                    end
                    else if (!is_space)
                    begin
                        err_next   = keep_first(err_reg, ST_SYNTAX);
                        phase_next = PH_ERR;
                    end
                end
                else if (phase_reg == PH_INT && is_digit)
                begin
                    if (|int_sum[67:63])
                    begin
                        err_next   = keep_first(err_reg, ST_OVF);
                        phase_next = PH_ERR;
                    end
                    else
                        num_next = int_sum[63:0];
                end
                else if (phase_reg == PH_FRAC && is_digit)
                begin
                    if (frac_sum[64] || frac_sum[63])
                    begin
                        err_next   = keep_first(err_reg, ST_OVF);
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        num_next = frac_sum[63:0];
                        if (fidx_reg != FRAC_LAST)
                            fidx_next = fidx_reg + 4'd1;
                    end
                end
                else if (phase_reg == PH_INT && c_reg == CH_DOT)
                begin
                    fidx_next  = 4'd0;
                    phase_next = PH_FRAC;
                end
            end
            S_NUMF:
            begin
                if (mop_reg == MOP_NONE)
                begin
                    term_next  = num_reg;
                    phase_next = PH_AFTER;
                end
                else if (div_zero)
                begin
                    err_next   = keep_first(err_reg, ST_DIV0);
                    phase_next = PH_ERR;
                end
            end
            S_WAIT:
            begin
                if (md_rsp.done)
                begin
                    if (md_rsp.ovf)
                    begin
                        err_next   = keep_first(err_reg, ST_OVF);
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        term_next  = md_result;
                        phase_next = PH_AFTER;
                    end
                end
            end
            S_OPER:
            begin
                if (c_reg == CH_PLUS || c_reg == CH_MINUS)
                begin
                    if (fold_ovf)
                    begin
                        err_next   = keep_first(err_reg, ST_OVF);
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        sum_next    = fold[63:0];
                        add_op_next = (c_reg == CH_MINUS);
                        mop_next    = MOP_NONE;
                        phase_next  = PH_NUM;
                    end
                end
                else if (c_reg == CH_STAR || c_reg == CH_SLASH)
                begin
                    mop_next   = (c_reg == CH_STAR) ? MOP_MUL : MOP_DIV;
                    phase_next = PH_NUM;
                end
                else
                begin
                    err_next   = keep_first(err_reg, ST_SYNTAX);
                    phase_next = PH_ERR;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    if (fin_status != ST_OK)
                        out_value_next = 64'sd0;
                    else
                        out_value_next = do_fold ? fold[63:0] : sum_reg;
                    phase_next  = PH_NUM;
                    mop_next    = MOP_NONE;
                    err_next    = ST_OK;
                    add_op_next = 1'b0;
                    fidx_next   = 4'd0;
                    sum_next    = 64'sd0;
                    term_next   = 64'd0;
                    num_next    = 64'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_NUM;
            mop_reg       <= MOP_NONE;
            err_reg       <= ST_OK;
            add_op_reg    <= 1'b0;
            fidx_reg      <= 4'd0;
            sum_reg       <= 64'sd0;
            term_reg      <= 64'd0;
            num_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            mop_reg       <= mop_next;
            err_reg       <= err_next;
            add_op_reg    <= add_op_next;
            fidx_reg      <= fidx_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            num_reg       <= num_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg          <= c_next;
        eot_reg        <= eot_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.status = out_status_reg;

    `DEE_ASSERT_IMP(a_err_value_zero, result.valid && result.status != ST_OK, result.value == 64'sd0)
    `DEE_ASSERT_IMP(a_busy_not_ready, md_rsp.busy, !text.ready)
    `DEE_ASSERT_IMP(a_err_phase, err_reg != ST_OK, phase_reg == PH_ERR)
    `DEE_ASSERT_ALWAYS(a_term_nonneg, !term_reg[63])

endmodule
`default_nettype wire

>>> test/decimal_expression_evaluator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module decimal_expression_evaluator_tb;
    import dee_pkg::*;

    localparam logic [31:0] TENTH_Q32 = 32'h1999_999A;
    localparam longint SUM_MIN = longint'(64'h8000_0000_0000_0000);
    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM = 14;
    localparam logic [63:0] ONE = 64'h1_0000_0000;

    logic clk;
    logic rst_n;

    dee_in_if tin();
    dee_out_if tout();

    decimal_expression_evaluator u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .text(tin),
        .result(tout)
    );

    // Evaluator state as seen by the predictor.
    longint      sum_q;
    logic [63:0] term_q;
    logic [63:0] num_q;
    logic [31:0] weight_q;
    logic        minus_q;
    mul_op_t     mop_q;
    phase_t      phase_q;
    status_t     err_q;

    logic [63:0] value_exp_q[$];
    status_t     status_exp_q[$];
    int          fail_count = 0;
    int          cycles = 0;
    bit          calm;
    int          stall_left = 0;

    string       dir_txt[N_DIRECTED];
    bit          dir_typed[N_DIRECTED];
    logic [63:0] dir_val[N_DIRECTED];
    status_t     dir_st[N_DIRECTED];

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic eval_clear();
        sum_q = 0;
        term_q = '0;
        num_q = '0;
        weight_q = TENTH_Q32;
        minus_q = 1'b0;
        mop_q = MOP_NONE;
        phase_q = PH_NUM;
        err_q = ST_OK;
    endtask

    task automatic eval_fail(status_t code);
        if (err_q == ST_OK)
            err_q = code;
        phase_q = PH_ERR;
    endtask

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic close_number();
        logic [127:0] wide;
        if (mop_q == MOP_MUL)
        begin
            wide = {64'b0, term_q} * {64'b0, num_q};
            if ((wide >> 32) > {64'b0, SMAX})
            begin
                eval_fail(ST_OVF);
                return;
            end
            term_q = wide[95:32];
        end
        else if (mop_q == MOP_DIV)
        begin
            if (num_q == 0)
            begin
                eval_fail(ST_DIV0);
                return;
            end
            wide = ({64'b0, term_q} << 32) / {64'b0, num_q};
            if (wide > {64'b0, SMAX})
            begin
                eval_fail(ST_OVF);
                return;
            end
            term_q = wide[63:0];
        end
        else
        begin
            term_q = num_q;
        end
        phase_q = PH_AFTER;
    endtask

    task automatic close_term();
        longint t;
        t = longint'(term_q);
        if (!minus_q)
        begin
            if (sum_q > longint'(SMAX) - t)
            begin
                eval_fail(ST_OVF);
                return;
            end
            sum_q = sum_q + t;
        end
        else
        begin
            if (sum_q < SUM_MIN + t)
            begin
                eval_fail(ST_OVF);
                return;
            end
            sum_q = sum_q - t;
        end
    endtask

    task automatic apply_operator(logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            close_term();
            if (err_q != ST_OK)
                return;
            minus_q = (c == CH_MINUS);
            mop_q = MOP_NONE;
            phase_q = PH_NUM;
        end
        else if (c == CH_STAR || c == CH_SLASH)
        begin
            mop_q = (c == CH_STAR) ? MOP_MUL : MOP_DIV;
            phase_q = PH_NUM;
        end
        else
        begin
            eval_fail(ST_SYNTAX);
        end
    endtask

    task automatic eval_char(logic [7:0] c, logic eot);
        logic [63:0] add;
        logic [3:0]  d;
        bit          digit;
        digit = c >= CH_ZERO && c <= CH_NINE;
        d = 4'(c - CH_ZERO);
        if (eot)
        begin
            if (phase_q == PH_NUM)
                eval_fail(ST_SYNTAX);
            else if (phase_q == PH_INT || phase_q == PH_FRAC)
                close_number();
            if (err_q == ST_OK && phase_q == PH_AFTER)
                close_term();
            value_exp_q.push_back(err_q == ST_OK ? 64'(sum_q) : 64'd0);
            status_exp_q.push_back(err_q);
            eval_clear();
            return;
        end
        case (phase_q)
            PH_NUM:
                if (!is_blank(c))
                begin
                    if (digit)
                    begin
                        num_q = {28'b0, d, 32'b0};
                        phase_q = PH_INT;
                    end
                    else
                    begin
                        eval_fail(ST_SYNTAX);
                    end
                end
            PH_INT, PH_FRAC:
                if (digit && phase_q == PH_INT)
                begin
                    add = {28'b0, d, 32'b0};
                    if (num_q > (SMAX - add) / 10)
                        eval_fail(ST_OVF);
                    else
                        num_q = num_q * 10 + add;
                end
                else if (digit)
                begin
                    add = 64'(d) * 64'(weight_q);
                    if (num_q > SMAX - add)
                    begin
                        eval_fail(ST_OVF);
                    end
                    else
                    begin
                        num_q = num_q + add;
                        weight_q = (weight_q + 32'd5) / 32'd10;
                    end
                end
                else if (c == CH_DOT && phase_q == PH_INT)
                begin
                    weight_q = TENTH_Q32;
                    phase_q = PH_FRAC;
                end
                else
                begin
                    close_number();
                    if (err_q == ST_OK && !is_blank(c))
                        apply_operator(c);
                end
            PH_AFTER:
                if (!is_blank(c))
                    apply_operator(c);
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic put_word(logic [7:0] c, logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tin.valid <= 1'b1;
        tin.ch <= c;
        tin.end_of_text <= eot;
        do @(posedge clk); while (!tin.ready);
        eval_char(c, eot);
    endtask

    task automatic send_text(logic [7:0] words[$]);
        foreach (words[i])
            put_word(words[i], 1'b0);
        put_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    task automatic build_expr(output logic [7:0] w[$]);
        int   terms;
        int   len;
        logic [7:0] ops[4];
        ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        w = {};
        terms = $urandom_range(1, 5);
        for (int t = 0; t < terms; t++)
        begin
            if ($urandom_range(0, 3) == 0)
                w.push_back(pick_blank());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
                w.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0)
            begin
                w.push_back(CH_DOT);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
                for (int k = 0; k < len; k++)
                    w.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0)
                w.push_back(pick_blank());
            if (t != terms - 1)
                w.push_back(ops[$urandom_range(0, 3)]);
        end
        case ($urandom_range(0, 9))
            0: w[$urandom_range(0, w.size() - 1)] = 8'($urandom_range(0, 255));
            1: w.push_back(ops[$urandom_range(0, 3)]);
            2: w.insert($urandom_range(0, w.size()), 8'($urandom_range(0, 255)));
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tout.ready <= 1'b0;
        end
        else
        begin
            if (tout.valid && tout.ready)
            begin
                if (value_exp_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    if (tout.value !== value_exp_q[0])
                    begin
                        $error("value: expected %h, actual %h", value_exp_q[0], tout.value);
                        fail_count = fail_count + 1;
                    end
                    if (tout.status !== status_exp_q[0])
                    begin
                        $error("status: expected %0d, actual %0d", status_exp_q[0], tout.status);
                        fail_count = fail_count + 1;
                    end
                    void'(value_exp_q.pop_front());
                    void'(status_exp_q.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                tout.ready <= 1'b0;
            end
            else
            begin
                tout.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    initial
    begin
        logic [7:0] words[$];
        dir_txt = '{"", "1", "7/0", "1 2", ".5", "+", "9999999999", "2147483647",
                    "2147483648", "3*4", "1.5+2.25*3", " 10 / 4 - 0.1",
                    "1.123456789012345", "2x", "\t3 *\t2\n", "5-", "1..2",
                    "2147483647.99999999999", "100/3*3", "0-2147483647-2147483647*2"};
        dir_typed = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 1, 0, 1, 1, 0, 0, 0};
        dir_val = '{0, ONE, 0, 0, 0, 0, 0, 64'h7FFF_FFFF_0000_0000, 0, 12 * ONE,
                    0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_st = '{ST_SYNTAX, ST_OK, ST_DIV0, ST_SYNTAX, ST_SYNTAX, ST_SYNTAX, ST_OVF,
                   ST_OK, ST_OVF, ST_OK, ST_OK, ST_OK, ST_OK, ST_SYNTAX, ST_OK,
                   ST_SYNTAX, ST_SYNTAX, ST_OK, ST_OK, ST_OK};
        calm = 1'b0;
        eval_clear();
        rst_n <= 1'b0;
        tin.valid <= 1'b0;
        tin.ch <= '0;
        tin.end_of_text <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            words = {};
            for (int k = 0; k < dir_txt[i].len(); k++)
                words.push_back(dir_txt[i][k]);
            send_text(words);
            if (dir_typed[i])
            begin
                value_exp_q[$] = dir_val[i];
                status_exp_q[$] = dir_st[i];
            end
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = ($urandom_range(0, 4) == 0);
            build_expr(words);
            send_text(words);
        end
        tin.valid <= 1'b0;

        while (value_exp_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
